// ===== sv/varint_frame_checker_crc32_macros.svh =====
// Assertion macros shared by the checker RTL.
`ifndef VARINT_FRAME_CHECKER_CRC32_MACROS_SVH
`define VARINT_FRAME_CHECKER_CRC32_MACROS_SVH

`ifndef ASSERT_OFF
// Property checked on every rising clk edge, off while rst_n is low.
`define VFC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed in %m");
// Condition that must never be true at a clock edge.
`define VFC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition in %m");
`else
`define VFC_ASSERT(lbl, prop)
`define VFC_ASSERT_NEVER(lbl, cond)
`endif

`endif

// ===== sv/vfc_pkg.sv =====
`timescale 1ns / 1ps

package vfc_pkg;

  // Length limit on a frame, as a power of two
  localparam int MAX_FRAME_LOG2 = 26;
  // Byte counter saturates at limit + 5, so needs one bit above the limit
  localparam int CNT_W = MAX_FRAME_LOG2 + 1;
  localparam logic [CNT_W-1:0] CNT_SAT =
    CNT_W'((64'd1 << MAX_FRAME_LOG2) + 64'd5);

  // CRC trailer held back by the delay line
  localparam int DLY_DEPTH = 4;

  // Last legal varint byte index (five bytes, 0..4)
  localparam logic [2:0] VARINT_LAST = 3'd4;

  // Reflected IEEE CRC-32
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Queue between front and back
  localparam int Q_AW    = 1;
  localparam int Q_DEPTH = 1 << Q_AW;

  typedef enum logic [2:0] {
    PH_HSIZE = 3'd0,
    PH_TSIZE = 3'd1,
    PH_NAME  = 3'd2,
    PH_HDR   = 3'd3,
    PH_MSG   = 3'd4,
    PH_SINK  = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    KIND_HSIZE  = 3'd0,
    KIND_TSIZE  = 3'd1,
    KIND_NAME   = 3'd2,
    KIND_HDR    = 3'd3,
    KIND_MSG    = 3'd4,
    KIND_STATUS = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_CRC       = 3'd2,
    ST_VARINT    = 3'd3,
    ST_ZERO_HDR  = 3'd4,
    ST_ZERO_TYPE = 3'd5,
    ST_EXCEED    = 3'd6,
    ST_LONG      = 3'd7
  } status_t;

  // Results caused by one input byte: optional byte item, optional status item
  typedef struct packed {
    logic        has_byte;
    logic        has_stat;
    kind_t       kind;
    logic [7:0]  byte_value;
    logic [31:0] header_len;
    logic [31:0] type_name_len;
    status_t     status;
  } pair_t;

  // One entry of the byte-wise CRC table (entry 1 is 0x77073096)
  function automatic logic [31:0] crc_entry(input logic [7:0] idx);
    logic [31:0] c;
    c = {24'd0, idx};
    for (int j = 0; j < 8; j++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Advance the CRC by one byte through the table
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    return (c >> 8) ^ crc_entry(c[7:0] ^ b);
  endfunction

endpackage

// ===== sv/vfc_if.sv =====
`timescale 1ns / 1ps

// Byte input channel
interface vfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_last;

  modport source (output valid, output data_byte, output frame_last, input ready);
  modport sink   (input valid, input data_byte, input frame_last, output ready);
endinterface

// Result channel
interface vfc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  byte_value;
  logic [31:0] header_len;
  logic [31:0] type_name_len;
  logic [2:0]  status;
  logic        frame_end;

  modport source (output valid, output kind, output byte_value, output header_len,
                  output type_name_len, output status, output frame_end, input ready);
  modport sink   (input valid, input kind, input byte_value, input header_len,
                  input type_name_len, input status, input frame_end, output ready);
endinterface

// ===== sv/varint_frame_checker_crc32.sv =====
`timescale 1ns / 1ps
// Channel  | Dir | Payload                                          | Request when
// in_ch    | in  | data_byte, frame_last                            | valid && ready
// out_ch   | out | kind, byte_value, header_len, type_name_len,     | valid && ready
//          |     | status, frame_end                                |
// One byte is taken per cycle while in_ch.ready is high; the front's CRC table step and parser set that rate.
// A byte leaves as a result four input bytes later, then two register stages on.
// A frame_last byte yields up to two results, which the result side sends one after the other.
// Synchronous active-low reset; no clearing pass, so the block is ready once reset is released.
// in_ch.ready drops only while the two-entry queue is full; out_ch stalls back-fill it.

`include "varint_frame_checker_crc32_macros.svh"

module varint_frame_checker_crc32 (
  input  logic       clk,
  input  logic       rst_n,
  vfc_in_if.sink     in_ch,
  vfc_out_if.source  out_ch
);

  logic           f_push;
  vfc_pkg::pair_t f_pair;
  logic           q_ready;
  logic           q_valid;
  logic           q_pop;
  vfc_pkg::pair_t q_head;

  // Front: delay line, CRC and section parser
  vfc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_ready (q_ready),
    .f_push  (f_push),
    .f_pair  (f_pair)
  );

  // Queue decoupling the two sides
  vfc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data (f_pair),
    .q_ready   (q_ready),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .head      (q_head)
  );

  // Back: serialises byte and status items onto the result channel
  vfc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .head    (q_head),
    .pop     (q_pop),
    .out_ch  (out_ch)
  );

  // Checks
  `VFC_ASSERT(a_last_gives_status, (in_ch.valid && in_ch.ready && in_ch.frame_last) |-> (f_push && f_pair.has_stat))
  `VFC_ASSERT(a_byte_item_clean, (out_ch.valid && (out_ch.kind != vfc_pkg::KIND_STATUS)) |-> ((out_ch.status == vfc_pkg::ST_OK) && !out_ch.frame_end))
  `VFC_ASSERT(a_back_refills, (!out_ch.valid && q_valid) |=> out_ch.valid)
  `VFC_ASSERT_NEVER(a_push_when_full, f_push && !q_ready)

endmodule

// ===== sv/vfc_front.sv =====
`timescale 1ns / 1ps

module vfc_front (
  input  logic                  clk,
  input  logic                  rst_n,
  vfc_in_if.sink                in_ch,
  input  logic                  q_ready,
  output logic                  f_push,
  output vfc_pkg::pair_t        f_pair
);

  logic [31:0]              crc_r,   crc_nxt;
  logic [7:0]               dly_r    [vfc_pkg::DLY_DEPTH];
  logic [7:0]               dly_nxt  [vfc_pkg::DLY_DEPTH];
  logic [vfc_pkg::CNT_W-1:0] cnt_r,  cnt_nxt;
  logic [31:0]              acc_r,   acc_nxt;
  logic [2:0]               vidx_r,  vidx_nxt;
  vfc_pkg::phase_t          phase_r, phase_nxt;
  logic [31:0]              hlen_r,  hlen_nxt;
  logic [31:0]              tlen_r,  tlen_nxt;
  logic [31:0]              left_r,  left_nxt;
  vfc_pkg::status_t         err_r,   err_nxt;

  logic                     accept;
  logic [7:0]               old_b;
  logic [31:0]              sh;
  logic [31:0]              acc_new;
  logic [31:0]              left_m;
  logic [31:0]              recv;
  logic                     emit_byte;
  vfc_pkg::kind_t           byte_kind;
  vfc_pkg::status_t         stat;

  assign accept      = in_ch.valid && q_ready;
  assign in_ch.ready = q_ready;
  assign old_b       = dly_r[0];
  assign left_m      = left_r - 32'd1;

  // Payload bits of the current varint byte at their place
  always_comb begin
    case (vidx_r)
      3'd0:    sh = {25'd0, old_b[6:0]};
      3'd1:    sh = {18'd0, old_b[6:0], 7'd0};
      3'd2:    sh = {11'd0, old_b[6:0], 14'd0};
      3'd3:    sh = {4'd0, old_b[6:0], 21'd0};
      3'd4:    sh = {old_b[3:0], 28'd0};
      default: sh = 32'd0;
    endcase
  end
  assign acc_new = acc_r | sh;

  // Next state: delay line, CRC, parser, status on the last byte
  always_comb begin
    crc_nxt   = crc_r;
    dly_nxt   = dly_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    vidx_nxt  = vidx_r;
    phase_nxt = phase_r;
    hlen_nxt  = hlen_r;
    tlen_nxt  = tlen_r;
    left_nxt  = left_r;
    err_nxt   = err_r;
    emit_byte = 1'b0;
    byte_kind = vfc_pkg::KIND_MSG;
    stat      = vfc_pkg::ST_OK;
    recv      = 32'd0;

    if (accept) begin
      for (int i = 0; i < vfc_pkg::DLY_DEPTH - 1; i++) begin
        dly_nxt[i] = dly_r[i+1];
      end
      dly_nxt[vfc_pkg::DLY_DEPTH-1] = in_ch.data_byte;
      if (cnt_r < vfc_pkg::CNT_SAT) begin
        cnt_nxt = cnt_r + vfc_pkg::CNT_W'(1);
      end

      // Byte leaving the delay line
      if (cnt_r >= vfc_pkg::CNT_W'(vfc_pkg::DLY_DEPTH)) begin
        crc_nxt = vfc_pkg::crc_byte(crc_r, old_b);
        case (phase_r)
          vfc_pkg::PH_HSIZE, vfc_pkg::PH_TSIZE: begin
            emit_byte = 1'b1;
            byte_kind = (phase_r == vfc_pkg::PH_HSIZE) ? vfc_pkg::KIND_HSIZE
                                                       : vfc_pkg::KIND_TSIZE;
            acc_nxt = acc_new;
            if (old_b[7]) begin
              if (vidx_r >= vfc_pkg::VARINT_LAST) begin
                err_nxt   = vfc_pkg::ST_VARINT;
                phase_nxt = vfc_pkg::PH_SINK;
              end else begin
                vidx_nxt = vidx_r + 3'd1;
              end
            end else if (phase_r == vfc_pkg::PH_HSIZE) begin
              hlen_nxt  = acc_new;
              acc_nxt   = 32'd0;
              vidx_nxt  = 3'd0;
              phase_nxt = vfc_pkg::PH_TSIZE;
            end else begin
              tlen_nxt = acc_new;
              acc_nxt  = 32'd0;
              vidx_nxt = 3'd0;
              if (hlen_r == 32'd0) begin
                err_nxt   = vfc_pkg::ST_ZERO_HDR;
                phase_nxt = vfc_pkg::PH_SINK;
              end else if (acc_new == 32'd0) begin
                err_nxt   = vfc_pkg::ST_ZERO_TYPE;
                phase_nxt = vfc_pkg::PH_SINK;
              end else begin
                phase_nxt = vfc_pkg::PH_NAME;
                left_nxt  = acc_new;
              end
            end
          end
          vfc_pkg::PH_NAME: begin
            emit_byte = 1'b1;
            byte_kind = vfc_pkg::KIND_NAME;
            if (left_m == 32'd0) begin
              phase_nxt = vfc_pkg::PH_HDR;
              left_nxt  = hlen_r;
            end else begin
              left_nxt = left_m;
            end
          end
          vfc_pkg::PH_HDR: begin
            emit_byte = 1'b1;
            byte_kind = vfc_pkg::KIND_HDR;
            left_nxt  = left_m;
            if (left_m == 32'd0) begin
              phase_nxt = vfc_pkg::PH_MSG;
            end
          end
          vfc_pkg::PH_MSG: begin
            emit_byte = 1'b1;
            byte_kind = vfc_pkg::KIND_MSG;
          end
          default: begin
            emit_byte = 1'b0;
          end
        endcase
      end

      // Closing status, in priority order
      if (in_ch.frame_last) begin
        recv = {dly_nxt[3], dly_nxt[2], dly_nxt[1], dly_nxt[0]};
        if (cnt_nxt < vfc_pkg::CNT_W'(vfc_pkg::DLY_DEPTH)) begin
          stat = vfc_pkg::ST_SHORT;
        end else if (recv != ~crc_nxt) begin
          stat = vfc_pkg::ST_CRC;
        end else if (err_nxt != vfc_pkg::ST_OK) begin
          stat = err_nxt;
        end else if (phase_nxt inside {vfc_pkg::PH_HSIZE, vfc_pkg::PH_TSIZE}) begin
          stat = vfc_pkg::ST_VARINT;
        end else if (phase_nxt inside {vfc_pkg::PH_NAME, vfc_pkg::PH_HDR}) begin
          stat = vfc_pkg::ST_EXCEED;
        end else if (cnt_nxt == vfc_pkg::CNT_SAT) begin
          stat = vfc_pkg::ST_LONG;
        end else begin
          stat = vfc_pkg::ST_OK;
        end
      end
    end
  end

  // Request to the queue
  assign f_push               = accept && (emit_byte || in_ch.frame_last);
  assign f_pair.has_byte      = emit_byte;
  assign f_pair.has_stat      = in_ch.frame_last;
  assign f_pair.kind          = byte_kind;
  assign f_pair.byte_value    = old_b;
  assign f_pair.header_len    = hlen_nxt;
  assign f_pair.type_name_len = tlen_nxt;
  assign f_pair.status        = stat;

  // Per-frame state; cleared by reset and after each last byte
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_ch.frame_last)) begin
      crc_r   <= vfc_pkg::CRC_INIT;
      cnt_r   <= '0;
      acc_r   <= 32'd0;
      vidx_r  <= 3'd0;
      phase_r <= vfc_pkg::PH_HSIZE;
      hlen_r  <= 32'd0;
      tlen_r  <= 32'd0;
      left_r  <= 32'd0;
      err_r   <= vfc_pkg::ST_OK;
    end else begin
      crc_r   <= crc_nxt;
      cnt_r   <= cnt_nxt;
      acc_r   <= acc_nxt;
      vidx_r  <= vidx_nxt;
      phase_r <= phase_nxt;
      hlen_r  <= hlen_nxt;
      tlen_r  <= tlen_nxt;
      left_r  <= left_nxt;
      err_r   <= err_nxt;
    end
  end

  // Delay line taps: payload only, read once the count shows them filled
  always_ff @(posedge clk) begin
    dly_r <= dly_nxt;
  end

endmodule

// ===== sv/vfc_queue.sv =====
`timescale 1ns / 1ps

module vfc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  vfc_pkg::pair_t push_data,
  output logic           q_ready,
  input  logic           pop,
  output logic           q_valid,
  output vfc_pkg::pair_t head
);

  vfc_pkg::pair_t          slot_r [vfc_pkg::Q_DEPTH];
  logic [vfc_pkg::Q_AW-1:0] wr_r, wr_nxt;
  logic [vfc_pkg::Q_AW-1:0] rd_r, rd_nxt;
  logic [vfc_pkg::Q_AW:0]   cnt_r, cnt_nxt;

  assign q_ready = (cnt_r != (vfc_pkg::Q_AW+1)'(vfc_pkg::Q_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign head    = slot_r[rd_r];

  // Pointer and fill updates
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push && q_ready) begin
      wr_nxt = wr_r + 1'b1;
    end
    if (pop && q_valid) begin
      rd_nxt = rd_r + 1'b1;
    end
    case ({push && q_ready, pop && q_valid})
      2'b10:   cnt_nxt = cnt_r + (vfc_pkg::Q_AW+1)'(1);
      2'b01:   cnt_nxt = cnt_r - (vfc_pkg::Q_AW+1)'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push && q_ready) begin
      slot_r[wr_r] <= push_data;
    end
  end

endmodule

// ===== sv/vfc_back.sv =====
`timescale 1ns / 1ps

module vfc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  vfc_pkg::pair_t head,
  output logic           pop,
  vfc_out_if.source      out_ch
);

  vfc_pkg::pair_t cur_r;
  logic           byte_pend_r, byte_pend_nxt;
  logic           stat_pend_r, stat_pend_nxt;
  logic           fire;
  logic           empty_after;

  assign out_ch.valid = byte_pend_r || stat_pend_r;
  assign fire         = out_ch.valid && out_ch.ready;

  // Holding register frees up when nothing is left after this cycle
  assign empty_after = !out_ch.valid || (fire && !(byte_pend_r && stat_pend_r));
  assign pop         = empty_after && q_valid;

  always_comb begin
    byte_pend_nxt = byte_pend_r;
    stat_pend_nxt = stat_pend_r;
    if (pop) begin
      byte_pend_nxt = head.has_byte;
      stat_pend_nxt = head.has_stat;
    end else if (fire) begin
      if (byte_pend_r) begin
        byte_pend_nxt = 1'b0;
      end else begin
        stat_pend_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pend_r <= 1'b0;
      stat_pend_r <= 1'b0;
    end else begin
      byte_pend_r <= byte_pend_nxt;
      stat_pend_r <= stat_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head;
    end
  end

  // Byte item goes first, then the status item
  assign out_ch.kind          = byte_pend_r ? cur_r.kind : vfc_pkg::KIND_STATUS;
  assign out_ch.byte_value    = byte_pend_r ? cur_r.byte_value : 8'd0;
  assign out_ch.header_len    = cur_r.header_len;
  assign out_ch.type_name_len = cur_r.type_name_len;
  assign out_ch.status        = byte_pend_r ? vfc_pkg::ST_OK : cur_r.status;
  assign out_ch.frame_end     = !byte_pend_r;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import vfc_pkg::*;

  // Result as it leaves the block
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  byte_value;
    logic [31:0] header_len;
    logic [31:0] type_name_len;
    status_t     status;
    logic        frame_end;
  } frame_result_t;

  // Directed stimulus: a raw byte, or the four-byte FCS of the frame so far
  typedef enum logic [1:0] {ROW_BYTE, ROW_FCS_GOOD, ROW_FCS_BAD} row_op_t;

  typedef struct packed {
    row_op_t    op;
    logic [7:0] data;
    logic       last;
    logic       pinned;
    status_t    want;
  } stim_row_t;

  // Receiver behaviour between long hold-offs
  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_PATTERN, RX_SPARSE} rx_mode_t;

  localparam longint FRAME_LIMIT = longint'(1) << MAX_FRAME_LOG2;
  localparam int     BYTE_TARGET = 440;
  localparam int     HOLD_CYCLES = 60;

  logic clk = 1'b0;
  logic rst_n;

  vfc_in_if  in_ch ();
  vfc_out_if out_ch ();

  varint_frame_checker_crc32 dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #4 clk = ~clk;

  // Frame model state
  logic [31:0] mdl_crc;
  logic [7:0]  mdl_dly [4];
  longint      mdl_cnt;
  logic [31:0] mdl_acc;
  int          mdl_vidx;
  phase_t      mdl_phase;
  logic [31:0] mdl_hlen;
  logic [31:0] mdl_tlen;
  logic [31:0] mdl_left;
  status_t     mdl_err;

  frame_result_t awaited_results [$];
  int          mismatches = 0;

  // Sender side
  logic [31:0] tx_crc;
  logic [7:0]  frame_bytes [$];
  int          bytes_sent = 0;
  int          burst_left = 0;

  // Receiver hold-off requests
  int          holds_wanted = 0;
  int          holds_done = 0;
  bit          rx_holding = 1'b0;

  // Directed frames: short, empty, minimal good, each latched error, overrun sections, CRC mismatch
  stim_row_t directed_rows [25] = '{
    // one byte then end: too short
    '{ROW_BYTE,     8'hFF, 1'b1, 1'b1, ST_SHORT},
    // nothing but an FCS of zero: size varint never started
    '{ROW_FCS_GOOD, 8'h00, 1'b0, 1'b1, ST_VARINT},
    // smallest well-formed frame
    '{ROW_BYTE,     8'h01, 1'b0, 1'b0, ST_OK},
    '{ROW_BYTE,     8'h01, 1'b0, 1'b0, ST_OK},
    '{ROW_BYTE,     8'h41, 1'b0, 1'b0, ST_OK},
    '{ROW_BYTE,     8'h00, 1'b0, 1'b0, ST_OK},
    '{ROW_BYTE,     8'hFF, 1'b0, 1'b0, ST_OK},
    '{ROW_FCS_GOOD, 8'h00, 1'b0, 1'b1, ST_OK},
    // header size of zero
    '{ROW_BYTE,     8'h00, 1'b0, 1'b0, ST_OK},
    '{ROW_BYTE,     8'h01, 1'b0, 1'b0, ST_OK},
    '{ROW_FCS_GOOD, 8'h00, 1'b0, 1'b1, ST_ZERO_HDR},
    // type-name size of zero
    '{ROW_BYTE,     8'h01, 1'b0, 1'b0, ST_OK},
    '{ROW_BYTE,     8'h00, 1'b0, 1'b0, ST_OK},
    '{ROW_FCS_GOOD, 8'h00, 1'b0, 1'b1, ST_ZERO_TYPE},
    // continuation still set on the fifth varint byte
    '{ROW_BYTE,     8'hFF, 1'b0, 1'b0, ST_OK},
    '{ROW_BYTE,     8'hFF, 1'b0, 1'b0, ST_OK},
    '{ROW_BYTE,     8'hFF, 1'b0, 1'b0, ST_OK},
    '{ROW_BYTE,     8'hFF, 1'b0, 1'b0, ST_OK},
    '{ROW_BYTE,     8'hFF, 1'b0, 1'b0, ST_OK},
    '{ROW_FCS_GOOD, 8'h00, 1'b0, 1'b1, ST_VARINT},
    // sizes claim more than the frame holds
    '{ROW_BYTE,     8'h05, 1'b0, 1'b0, ST_OK},
    '{ROW_BYTE,     8'h01, 1'b0, 1'b0, ST_OK},
    '{ROW_FCS_GOOD, 8'h00, 1'b0, 1'b1, ST_EXCEED},
    // corrupted FCS
    '{ROW_BYTE,     8'h01, 1'b0, 1'b0, ST_OK},
    '{ROW_FCS_BAD,  8'h00, 1'b0, 1'b1, ST_CRC}
  };

  // Bit-serial reflected CRC-32 step
  function automatic logic [31:0] crc32_next(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  task automatic clear_frame_model();
    mdl_crc   = CRC_INIT;
    foreach (mdl_dly[i]) mdl_dly[i] = 8'h00;
    mdl_cnt   = 0;
    mdl_acc   = '0;
    mdl_vidx  = 0;
    mdl_phase = PH_HSIZE;
    mdl_hlen  = '0;
    mdl_tlen  = '0;
    mdl_left  = '0;
    mdl_err   = ST_OK;
  endtask

  // Advance the frame model by one accepted byte and queue what it yields
  task automatic predict_frame_byte(input logic [7:0] b, input logic last);
    logic [7:0]  oldest;
    logic [31:0] rx_fcs;
    bit          leaving;
    bit          shown;
    kind_t       k;
    status_t     st;
    oldest  = mdl_dly[0];
    leaving = mdl_cnt >= 4;
    mdl_dly[0] = mdl_dly[1];
    mdl_dly[1] = mdl_dly[2];
    mdl_dly[2] = mdl_dly[3];
    mdl_dly[3] = b;
    if (mdl_cnt < FRAME_LIMIT + 5) mdl_cnt++;

    // byte leaving the delay line is classified by section
    if (leaving) begin
      mdl_crc = crc32_next(mdl_crc, oldest);
      shown = 1'b1;
      k = KIND_MSG;
      case (mdl_phase)
        PH_HSIZE, PH_TSIZE: begin
          k = (mdl_phase == PH_HSIZE) ? KIND_HSIZE : KIND_TSIZE;
          if (mdl_vidx <= 4) mdl_acc |= {25'd0, oldest[6:0]} << (7 * mdl_vidx);
          if (oldest[7]) begin
            if (mdl_vidx >= 4) begin
              mdl_err   = ST_VARINT;
              mdl_phase = PH_SINK;
            end else begin
              mdl_vidx++;
            end
          end else if (mdl_phase == PH_HSIZE) begin
            mdl_hlen  = mdl_acc;
            mdl_acc   = '0;
            mdl_vidx  = 0;
            mdl_phase = PH_TSIZE;
          end else begin
            mdl_tlen = mdl_acc;
            mdl_acc  = '0;
            mdl_vidx = 0;
            if (mdl_hlen == 0) begin
              mdl_err   = ST_ZERO_HDR;
              mdl_phase = PH_SINK;
            end else if (mdl_tlen == 0) begin
              mdl_err   = ST_ZERO_TYPE;
              mdl_phase = PH_SINK;
            end else begin
              mdl_phase = PH_NAME;
              mdl_left  = mdl_tlen;
            end
          end
        end
        PH_NAME: begin
          k = KIND_NAME;
          mdl_left--;
          if (mdl_left == 0) begin
            mdl_phase = PH_HDR;
            mdl_left  = mdl_hlen;
          end
        end
        PH_HDR: begin
          k = KIND_HDR;
          mdl_left--;
          if (mdl_left == 0) mdl_phase = PH_MSG;
        end
        PH_MSG: k = KIND_MSG;
        default: shown = 1'b0;
      endcase
      if (shown) awaited_results.push_back('{k, oldest, mdl_hlen, mdl_tlen, ST_OK, 1'b0});
    end

    // closing status, in priority order
    if (last) begin
      if (mdl_cnt < 4) begin
        st = ST_SHORT;
      end else begin
        rx_fcs = {mdl_dly[3], mdl_dly[2], mdl_dly[1], mdl_dly[0]};
        if (rx_fcs != ~mdl_crc) st = ST_CRC;
        else if (mdl_err != ST_OK) st = mdl_err;
        else if (mdl_phase == PH_HSIZE || mdl_phase == PH_TSIZE) st = ST_VARINT;
        else if (mdl_phase == PH_NAME || mdl_phase == PH_HDR) st = ST_EXCEED;
        else if (mdl_cnt - 4 > FRAME_LIMIT) st = ST_LONG;
        else st = ST_OK;
      end
      awaited_results.push_back('{KIND_STATUS, 8'h00, mdl_hlen, mdl_tlen, st, 1'b1});
      clear_frame_model();
    end
  endtask

  // Offer one byte; called and returning at a falling edge, valid left high
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (rx_holding) gap = 0;
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.frame_last <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_frame_byte(b, last);
    tx_crc = last ? CRC_INIT : crc32_next(tx_crc, b);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Little-endian FCS over the frame so far, last on its final byte
  task automatic send_fcs(input bit intact);
    logic [31:0] fcs;
    fcs = ~tx_crc;
    if (!intact) fcs ^= 32'h1 << $urandom_range(0, 31);
    for (int i = 0; i < 4; i++) send_byte(fcs[8*i +: 8], i == 3);
  endtask

  // Sender pauses until every awaited result is in
  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic int varint_pad();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
  endfunction

  // Mostly small sections, now and then a long one
  function automatic logic [31:0] pick_size();
    if ($urandom_range(0, 19) == 0) return $urandom_range(100, 160);
    return $urandom_range(1, 8);
  endfunction

  // Varint, possibly padded with empty continuation bytes; spare top bits
  // of a fifth byte are filled at random
  task automatic push_varint(input logic [31:0] v, input int extra);
    int         nb;
    logic [7:0] b;
    nb = 1;
    while (nb < 5 && (v >> (7 * nb)) != 0) nb++;
    nb = nb + extra;
    if (nb > 5) nb = 5;
    for (int i = 0; i < nb; i++) begin
      b[6:0] = 7'(v >> (7 * i));
      b[7]   = (i < nb - 1) ? 1'b1 : 1'b0;
      if (i == 4) b[6:4] = 3'($urandom);
      frame_bytes.push_back(b);
    end
  endtask

  task automatic push_noise(input int n);
    repeat (n) frame_bytes.push_back(8'($urandom));
  endtask

  // One random frame: mostly well-formed, the rest broken in one way each
  task automatic run_random_frame();
    int          pick;
    int          n;
    longint      room;
    logic [31:0] hl;
    logic [31:0] tl;
    bit          intact;
    frame_bytes.delete();
    pick   = $urandom_range(0, 99);
    intact = 1'b1;
    hl     = pick_size();
    tl     = pick_size();
    if (pick < 62) begin
      push_varint(hl, varint_pad());
      push_varint(tl, varint_pad());
      push_noise(int'(hl + tl) + $urandom_range(0, 12));
      intact = pick < 55;
    end else if (pick < 68) begin
      push_varint(32'd0, varint_pad());
      push_varint(tl, varint_pad());
      push_noise($urandom_range(0, 8));
    end else if (pick < 73) begin
      push_varint(hl, varint_pad());
      push_varint(32'd0, varint_pad());
      push_noise($urandom_range(0, 8));
    end else if (pick < 79) begin
      if ($urandom_range(0, 1)) push_varint(hl, varint_pad());
      repeat (5) frame_bytes.push_back(8'h80 | 8'($urandom));
      push_noise($urandom_range(0, 8));
    end else if (pick < 86) begin
      // sections run past the end of the data
      if ($urandom_range(0, 2) == 0) hl = $urandom | 32'h1;
      if ($urandom_range(0, 2) == 0) tl = $urandom | 32'h1;
      push_varint(hl, varint_pad());
      push_varint(tl, varint_pad());
      room = longint'(hl) + longint'(tl) - 1;
      n = (room > 24) ? 24 : int'(room);
      push_noise($urandom_range(0, n));
    end else if (pick < 91) begin
      // data ends inside a size varint
      if ($urandom_range(0, 1)) push_varint(hl, varint_pad());
      repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'h80 | 8'($urandom));
    end else if (pick < 95) begin
      // fewer bytes than an FCS
      push_noise($urandom_range(1, 3));
      foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
      return;
    end else begin
      push_noise($urandom_range(0, 20));
      intact = $urandom_range(0, 1);
    end
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], 1'b0);
    send_fcs(intact);
  endtask

  task automatic report_mismatch(input string what, input frame_result_t want,
                                 input frame_result_t seen);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected kind=%0d byte=%02h hlen=%0d tlen=%0d status=%0d end=%0b",
               what, want.kind, want.byte_value, want.header_len, want.type_name_len,
               want.status, want.frame_end);
      $display("    actual   kind=%0d byte=%02h hlen=%0d tlen=%0d status=%0d end=%0b",
               seen.kind, seen.byte_value, seen.header_len, seen.type_name_len,
               seen.status, seen.frame_end);
    end
  endtask

  // Result checker: each accepted request against the oldest awaited result
  always @(posedge clk) begin
    frame_result_t seen;
    frame_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen = '{kind_t'(out_ch.kind), out_ch.byte_value, out_ch.header_len,
               out_ch.type_name_len, status_t'(out_ch.status), out_ch.frame_end};
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected result", '0, seen);
      end else begin
        want = awaited_results.pop_front();
        if (seen.kind !== want.kind || seen.byte_value !== want.byte_value ||
            seen.header_len !== want.header_len ||
            seen.type_name_len !== want.type_name_len ||
            seen.status !== want.status || seen.frame_end !== want.frame_end) begin
          report_mismatch("result mismatch", want, seen);
        end
      end
    end
  end

  // Receiver: long hold-offs on request, otherwise a changing stall pattern
  initial begin
    rx_mode_t   mode;
    int         mode_left;
    int         hold_left;
    logic [7:0] pattern;
    mode      = RX_FREE;
    mode_left = 0;
    hold_left = 0;
    pattern   = 8'hFF;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 80);
        pattern   = 8'($urandom) | 8'h01;
      end
      mode_left--;
      if (holds_done != holds_wanted) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        rx_holding = 1'b1;
        out_ch.ready <= 1'b0;
      end else begin
        rx_holding = 1'b0;
        case (mode)
          RX_FREE:    out_ch.ready <= 1'b1;
          RX_COIN:    out_ch.ready <= 1'($urandom);
          RX_PATTERN: out_ch.ready <= pattern[0];
          default:    out_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
        pattern = {pattern[0], pattern[7:1]};
      end
    end
  end

  // Overall time limit
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Stimulus
  initial begin
    int frame_idx;
    frame_idx = 0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = 8'h00;
    in_ch.frame_last = 1'b0;
    tx_crc = CRC_INIT;
    clear_frame_model();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part
    foreach (directed_rows[r]) begin
      case (directed_rows[r].op)
        ROW_BYTE:     send_byte(directed_rows[r].data, directed_rows[r].last);
        ROW_FCS_GOOD: send_fcs(1'b1);
        default:      send_fcs(1'b0);
      endcase
      if (directed_rows[r].pinned)
        awaited_results[awaited_results.size() - 1].status = directed_rows[r].want;
    end

    // random frames, with two long receiver hold-offs and one full drain
    while (bytes_sent < BYTE_TARGET) begin
      frame_idx++;
      if (frame_idx == 3 || frame_idx == 15) holds_wanted++;
      if (frame_idx == 8) wait_results_drained();
      run_random_frame();
    end

    wait_results_drained();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
